/* src/mm_pkg.sv */
// Shared types, constants and helpers for the matrix multiply block.
package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W       = 4;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int SUM_W       = 35;
	localparam int OUT_W       = ((SUM_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = CFG_IDX_W'(2);

	// Tags that travel with one multiply-accumulate request.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic fin;
	} mac_ctl_t;

	// Zero reads as one, anything above the maximum reads as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
	                                               input logic [DIM_W:0] max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if ({1'b0, v} > max_dim) begin
			r = max_dim[DIM_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/mm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/mm_mac.sv */
// Shared multiply-accumulate unit: registered product, then running sum.
module mm_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               run,
	input  mm_pkg::mac_ctl_t                   ctl,
	input  logic signed [mm_pkg::ELEM_W-1:0]   a,
	input  logic signed [mm_pkg::ELEM_W-1:0]   b,
	output logic                               res_valid,
	output logic                               res_fin,
	output logic signed [mm_pkg::SUM_W-1:0]    res_sum
);

	mm_pkg::mac_ctl_t                   ctl_s2;
	logic signed [mm_pkg::PROD_W-1:0]   prod_s2;
	logic signed [mm_pkg::SUM_W-1:0]    acc_q;
	logic signed [mm_pkg::SUM_W-1:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (run) begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			prod_s2 <= a * b;
		end
		if (run && ctl_s2.valid && !ctl_s2.last) begin
			acc_q <= sum;
		end
	end

	// Restart the sum on the first product of each result element.
	assign sum = (ctl_s2.first ? '0 : acc_q) + mm_pkg::SUM_W'(prod_s2);

	assign res_valid = ctl_s2.valid && ctl_s2.last;
	assign res_fin   = ctl_s2.fin;
	assign res_sum   = sum;

endmodule

/* src/matrix_multiply_top.sv */
// Top level of the matrix multiply block: load sequencer, stores and output register.
// Loading: s_tready is high while loading; elements of A, then of B, are taken in order.
// Compute: the element that completes B starts rows_a*inner_dim*cols_b requests of
//   multiply-accumulate on one shared MAC, one product per cycle unless the output stalls; s_tready stays low.
// Pipeline: a request is tagged in ctl_s1 as the stores read, the MAC registers product and tag,
//   then the output register captures the finished sum; output stalls freeze the MAC.
// Reset: dimensions return to 8 and the load count to zero; the stores are not cleared.
module matrix_multiply_top #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mm_pkg::ELEM_W-1:0]        s_tdata,   // [15:0] element_value
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mm_pkg::OUT_W-1:0]         m_tdata,   // [34:0] sum_value, rest zero
	output logic                             m_tlast,   // last_flag
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]         cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W  = $clog2(2 * DEPTH + 1);
	localparam int DIM_W  = mm_pkg::DIM_W;
	localparam logic [DIM_W:0] MaxDimV = (DIM_W + 1)'(MAX_DIM);

	typedef enum logic {
		ST_LOAD,
		ST_CALC
	} state_t;

	state_t state_q;

	// Configuration registers keep the written bits; clamping happens on use.
	logic [DIM_W-1:0] rows_a_q;
	logic [DIM_W-1:0] inner_dim_q;
	logic [DIM_W-1:0] cols_b_q;

	logic [LEN_W-1:0]  load_cnt_q;
	logic [DIM_W-1:0]  i_q;
	logic [DIM_W-1:0]  j_q;
	logic [DIM_W-1:0]  k_q;
	logic [ADDR_W-1:0] a_ptr_q;
	logic [ADDR_W-1:0] b_ptr_q;
	logic [ADDR_W-1:0] row_base_q;

	mm_pkg::mac_ctl_t  ctl_s1;

	logic                      out_valid_q;
	logic                      out_last_q;
	logic [mm_pkg::SUM_W-1:0]  out_sum_q;

	logic [DIM_W-1:0]   m_dim;
	logic [DIM_W-1:0]   n_dim;
	logic [DIM_W-1:0]   p_dim;
	logic [2*DIM_W-1:0] mn_prod;
	logic [2*DIM_W-1:0] np_prod;
	logic [LEN_W-1:0]   a_len;
	logic [LEN_W-1:0]   b_len;
	logic [LEN_W-1:0]   total_len;
	logic [LEN_W-1:0]   cnt_next;
	logic [LEN_W-1:0]   b_off;

	logic run;
	logic accept;
	logic cfg_hit;
	logic in_a;
	logic load_done;
	logic issue;
	logic k_last;
	logic j_last;
	logic i_last;

	logic [mm_pkg::ELEM_W-1:0] a_rdata;
	logic [mm_pkg::ELEM_W-1:0] b_rdata;

	logic                             res_valid;
	logic                             res_fin;
	logic signed [mm_pkg::SUM_W-1:0]  res_sum;

	// Effective dimensions and load lengths.
	assign m_dim     = mm_pkg::clamp_dim(rows_a_q, MaxDimV);
	assign n_dim     = mm_pkg::clamp_dim(inner_dim_q, MaxDimV);
	assign p_dim     = mm_pkg::clamp_dim(cols_b_q, MaxDimV);
	assign mn_prod   = m_dim * n_dim;
	assign np_prod   = n_dim * p_dim;
	assign a_len     = LEN_W'(mn_prod);
	assign b_len     = LEN_W'(np_prod);
	assign total_len = a_len + b_len;

	// The pipeline advances unless a finished result is waiting and not taken.
	assign run = !out_valid_q || m_tready;

	assign s_tready  = (state_q == ST_LOAD);
	assign accept    = s_tvalid && s_tready;
	assign cfg_hit   = cfg_we && (cfg_index == mm_pkg::CFG_ROWS_A ||
	                              cfg_index == mm_pkg::CFG_INNER_DIM ||
	                              cfg_index == mm_pkg::CFG_COLS_B);

	assign in_a      = load_cnt_q < a_len;
	assign cnt_next  = load_cnt_q + LEN_W'(1);
	assign b_off     = load_cnt_q - a_len;
	assign load_done = accept && !in_a && (cnt_next == total_len);

	// Loop position of the current MAC request.
	assign issue  = (state_q == ST_CALC) && run;
	assign k_last = (k_q == n_dim - DIM_W'(1));
	assign j_last = (j_q == p_dim - DIM_W'(1));
	assign i_last = (i_q == m_dim - DIM_W'(1));

	mm_ram #(
		.WIDTH (mm_pkg::ELEM_W),
		.DEPTH (DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (accept && in_a),
		.waddr (load_cnt_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (run),
		.raddr (a_ptr_q),
		.rdata (a_rdata)
	);

	mm_ram #(
		.WIDTH (mm_pkg::ELEM_W),
		.DEPTH (DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (accept && !in_a),
		.waddr (b_off[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (run),
		.raddr (b_ptr_q),
		.rdata (b_rdata)
	);

	mm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.ctl       (ctl_s1),
		.a         (a_rdata),
		.b         (b_rdata),
		.res_valid (res_valid),
		.res_fin   (res_fin),
		.res_sum   (res_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rows_a_q    <= mm_pkg::DIM_RESET;
			inner_dim_q <= mm_pkg::DIM_RESET;
			cols_b_q    <= mm_pkg::DIM_RESET;
			load_cnt_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			a_ptr_q     <= '0;
			b_ptr_q     <= '0;
			row_base_q  <= '0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_sum_q   <= '0;
		end else begin
			// Register writes; any valid index abandons a partial load.
			if (cfg_we) begin
				unique case (cfg_index)
					mm_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data;
					mm_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data;
					mm_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_LOAD: begin
					if (cfg_hit) begin
						load_cnt_q <= '0;
					end else if (load_done) begin
						// Last element of B: start the product sweep.
						load_cnt_q <= '0;
						state_q    <= ST_CALC;
						i_q        <= '0;
						j_q        <= '0;
						k_q        <= '0;
						a_ptr_q    <= '0;
						b_ptr_q    <= '0;
						row_base_q <= '0;
					end else if (accept) begin
						load_cnt_q <= cnt_next;
					end
				end
				ST_CALC: begin
					if (run) begin
						if (!k_last) begin
							// Walk along row i of A and down column j of B.
							k_q     <= k_q + DIM_W'(1);
							a_ptr_q <= a_ptr_q + ADDR_W'(1);
							b_ptr_q <= b_ptr_q + ADDR_W'(p_dim);
						end else begin
							k_q <= '0;
							if (!j_last) begin
								j_q     <= j_q + DIM_W'(1);
								a_ptr_q <= row_base_q;
								b_ptr_q <= ADDR_W'(j_q) + ADDR_W'(1);
							end else begin
								j_q     <= '0;
								b_ptr_q <= '0;
								if (!i_last) begin
									i_q        <= i_q + DIM_W'(1);
									row_base_q <= row_base_q + ADDR_W'(n_dim);
									a_ptr_q    <= row_base_q + ADDR_W'(n_dim);
								end else begin
									state_q <= ST_LOAD;
								end
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			// Tag the request that the stores read at this edge.
			if (run) begin
				if (issue) begin
					ctl_s1 <= '{valid: 1'b1,
					            first: (k_q == '0),
					            last:  k_last,
					            fin:   k_last && j_last && i_last};
				end else begin
					ctl_s1 <= '0;
				end
			end

			// Output register: capture a finished sum, drop it once taken.
			if (run && res_valid) begin
				out_valid_q <= 1'b1;
				out_last_q  <= res_fin;
				out_sum_q   <= res_sum;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(mm_pkg::OUT_W - mm_pkg::SUM_W){1'b0}}, out_sum_q};

	// The load count never reaches the end of the current load.
	a_load_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (load_cnt_q < total_len))
		else $error("load count beyond matrix sizes");

	// The request that closes the last result element ends the sweep.
	a_fin_ends_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && k_last && j_last && i_last) |=> (state_q == ST_LOAD))
		else $error("sweep did not end after final request");

	// The element that completes B starts the sweep.
	a_done_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(load_done && !cfg_hit) |=> (state_q == ST_CALC))
		else $error("completed load did not start compute");

	// A finished sum held back by a stall is still there next cycle.
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !run) |=> res_valid)
		else $error("finished sum lost during output stall");

endmodule

/* test/matrix_multiply_checker.sv */
// Checker for the matrix multiply block: tracks loads, predicts each product matrix and compares results.
module matrix_multiply_checker #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [mm_pkg::ELEM_W-1:0]    s_tdata,          // [15:0] element_value
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [mm_pkg::OUT_W-1:0]     m_tdata,          // [34:0] sum_value, rest zero
	input  logic                         m_tlast,          // last_flag
	input  logic                         cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
	output int                           fail_count,
	output int                           open_results,
	output int                           checked_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_CAP = 100;
	localparam int ELEM_W     = mm_pkg::ELEM_W;
	localparam int SUM_W      = mm_pkg::SUM_W;
	localparam int OUT_W      = mm_pkg::OUT_W;
	localparam int DIM_W      = mm_pkg::DIM_W;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             last;
	} c_elem_t;

	logic [ELEM_W-1:0] a_elems [MAX_DIM*MAX_DIM];
	logic [ELEM_W-1:0] b_elems [MAX_DIM*MAX_DIM];
	logic [DIM_W-1:0]  rows_reg;
	logic [DIM_W-1:0]  inner_reg;
	logic [DIM_W-1:0]  cols_reg;
	int                loaded;
	c_elem_t           c_elems_q [$];
	int                n_fail    = 0;
	int                n_checked = 0;

	// Zero acts as one, anything above the maximum acts as the maximum.
	function automatic int dim_used(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int      m, n, p;
		longint  acc;
		c_elem_t want;
		if (!arst_n) begin
			rows_reg  = mm_pkg::DIM_RESET;
			inner_reg = mm_pkg::DIM_RESET;
			cols_reg  = mm_pkg::DIM_RESET;
			loaded    = 0;
			c_elems_q.delete();
			fail_count      <= 0;
			open_results    <= 0;
			checked_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mm_pkg::CFG_ROWS_A: begin
						rows_reg = cfg_data;
						loaded   = 0;
					end
					mm_pkg::CFG_INNER_DIM: begin
						inner_reg = cfg_data;
						loaded    = 0;
					end
					mm_pkg::CFG_COLS_B: begin
						cols_reg = cfg_data;
						loaded   = 0;
					end
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				if (c_elems_q.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_CAP)
						$display("%0t: result with nothing expected, expected none, actual %h last %b",
							$time, m_tdata, m_tlast);
				end else begin
					want = c_elems_q.pop_front();
					n_checked++;
					if (m_tdata !== OUT_W'(want.sum)) begin
						n_fail++;
						if (n_fail <= REPORT_CAP)
							$display("%0t: sum_value expected %h, actual %h",
								$time, OUT_W'(want.sum), m_tdata);
					end
					if (m_tlast !== want.last) begin
						n_fail++;
						if (n_fail <= REPORT_CAP)
							$display("%0t: last_flag expected %b, actual %b",
								$time, want.last, m_tlast);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				m = dim_used(rows_reg);
				n = dim_used(inner_reg);
				p = dim_used(cols_reg);
				if (loaded < m * n)
					a_elems[loaded] = s_tdata;
				else
					b_elems[loaded - m * n] = s_tdata;
				loaded++;
				// B is complete: C follows in row-major order, last flag on the final one.
				if (loaded == m * n + n * p) begin
					for (int i = 0; i < m; i++) begin
						for (int j = 0; j < p; j++) begin
							acc = 0;
							for (int k = 0; k < n; k++)
								acc += longint'($signed(a_elems[i * n + k])) *
									longint'($signed(b_elems[k * p + j]));
							want.sum  = acc[SUM_W-1:0];
							want.last = (i == m - 1) && (j == p - 1);
							c_elems_q.push_back(want);
						end
					end
					loaded = 0;
				end
			end

			fail_count      <= n_fail;
			open_results    <= c_elems_q.size();
			checked_results <= n_checked;
		end
	end

endmodule

/* test/tb_top.sv */
// Testbench top for the matrix multiply block: clock, reset, element stimulus, result stalls, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ELEM_W      = mm_pkg::ELEM_W;
	localparam int OUT_W       = mm_pkg::OUT_W;
	localparam int CFG_IDX_W   = mm_pkg::CFG_IDX_W;
	localparam int DIM_W       = mm_pkg::DIM_W;
	localparam int MAX_DIM_DEF = mm_pkg::MAX_DIM_DEF;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int ELEMENT_TARGET = 220;   // stop the random part once this many went in
	localparam int QUIET_TAIL     = 40;    // last stretch of elements runs with no idling
	localparam int SETTLE_CYCLES  = 8;     // pipeline is 3 deep, leave some margin
	localparam int LONG_HOLD      = 300;   // one long result stall to back up the block
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer of any kind

	localparam logic [ELEM_W-1:0] MOST_NEG  = 16'h8000;
	localparam logic [ELEM_W-1:0] MOST_POS  = 16'h7FFF;
	localparam logic [ELEM_W-1:0] MINUS_ONE = 16'hFFFF;
	localparam logic [ELEM_W-1:0] ONE_LSB   = 16'h0001;
	localparam logic [ELEM_W-1:0] ZERO      = 16'h0000;

	typedef enum {FILL_RANDOM, FILL_CORNERS, FILL_MOST_NEG} fill_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [ELEM_W-1:0]    s_tdata   = '0;       // [15:0] element_value
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;              // [34:0] sum_value, rest zero
	logic                 m_tlast;              // last_flag
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = mm_pkg::CFG_ROWS_A;
	logic [DIM_W-1:0]     cfg_data  = '0;

	int fail_count;
	int open_results;
	int checked_results;

	// Knobs shared between the request side and the result side.
	bit src_gaps    = 1'b0;
	bit sink_stalls = 1'b0;
	bit hold_req    = 1'b0;
	int elems_sent    = 0;
	int loads_dropped = 0;
	int settings_used = 0;

	matrix_multiply_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix_multiply_checker c_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.open_results    (open_results),
		.checked_results (checked_results)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Write all three dimension registers on consecutive edges, then drop the enable.
	// Any write also restarts the load, so this doubles as a way to abandon one.
	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
	                        input logic [DIM_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= mm_pkg::CFG_ROWS_A;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= mm_pkg::CFG_INNER_DIM;
		cfg_data  <= inner;
		@(posedge clk);
		cfg_index <= mm_pkg::CFG_COLS_B;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offer one element and hold it until the block takes the request.
	// Valid stays high afterwards so back-to-back requests need no extra edge.
	task automatic send_element(input logic [ELEM_W-1:0] v);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do
			@(posedge clk);
		while (!s_tready);
		elems_sent++;
	endtask

	function automatic logic [ELEM_W-1:0] pick_element(input fill_t fill);
		case (fill)
			FILL_MOST_NEG: return MOST_NEG;
			FILL_CORNERS: begin
				case ($urandom_range(0, 4))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return MINUS_ONE;
					3: return ONE_LSB;
					default: return ZERO;
				endcase
			end
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	task automatic send_load(input int count, input fill_t fill);
		for (int i = 0; i < count; i++)
			send_element(pick_element(fill));
	endtask

	// Drop valid, wait for every expected result, then let the pipeline drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly small dimensions so loads stay short; the top end shows up now and then.
	function automatic int pick_dim();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(4, MAX_DIM_DEF);
		return $urandom_range(1, 3);
	endfunction

	// Encode a dimension, sometimes through the out-of-range register values.
	function automatic logic [DIM_W-1:0] raw_dim(input int d);
		if (d == 1 && $urandom_range(0, 1) == 0)
			return '0;
		if (d == MAX_DIM_DEF && $urandom_range(0, 1) == 0)
			return DIM_W'($urandom_range(MAX_DIM_DEF + 1, (1 << DIM_W) - 1));
		return DIM_W'(d);
	endfunction

	// Result side: random short stalls, plus one long hold-off on request.
	initial begin : result_sink
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && m_tvalid) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// End the run if nothing moves on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired after %0d idle cycles", $time, quiet);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int    m, n, p, total;
		fill_t fill;

		// Hold reset, then release it on an edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Zero in every register acts as 1x1 times 1x1; three products
		// back to back, so each finished load must restart at A on its own.
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		set_dims(DIM_W'(0), DIM_W'(0), DIM_W'(0));
		send_element(MOST_POS);
		send_element(MOST_POS);
		send_element(MOST_POS);
		send_element(MOST_NEG);
		send_element(MINUS_ONE);
		send_element(ONE_LSB);
		settle();

		// Abandon a partial load: A of 1x2 plus one element of B, then rewrite the registers.
		set_dims(DIM_W'(1), DIM_W'(2), DIM_W'(1));
		send_load(3, FILL_RANDOM);
		loads_dropped++;
		settle();
		set_dims(DIM_W'(2), DIM_W'(1), DIM_W'(2));
		send_load(4, FILL_CORNERS);
		settle();

		// Widest sum: inner dimension written above the maximum, all most-negative inputs.
		set_dims(DIM_W'(1), DIM_W'((1 << DIM_W) - 1), DIM_W'(1));
		send_load(16, FILL_MOST_NEG);
		settle();

		// Pressure: 8x1 times 1x8 gives 64 results per load. Stall the result side for a
		// long stretch on the first one while the next load is already being offered.
		set_dims(DIM_W'(MAX_DIM_DEF), DIM_W'(1), DIM_W'(MAX_DIM_DEF));
		hold_req = 1'b1;
		send_load(2 * MAX_DIM_DEF, FILL_RANDOM);
		send_load(2 * MAX_DIM_DEF, FILL_CORNERS);
		settle();

		// Random part: random shapes and content, sometimes two loads per setting,
		// sometimes a load cut short by the next register write.
		while (elems_sent < ELEMENT_TARGET) begin
			if (elems_sent >= ELEMENT_TARGET - QUIET_TAIL) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end else begin
				src_gaps    = $urandom_range(0, 2) != 0;
				sink_stalls = $urandom_range(0, 2) != 0;
			end
			m = pick_dim();
			n = pick_dim();
			p = pick_dim();
			total = m * n + n * p;
			case ($urandom_range(0, 7))
				0: fill = FILL_CORNERS;
				1: fill = FILL_MOST_NEG;
				default: fill = FILL_RANDOM;
			endcase
			set_dims(raw_dim(m), raw_dim(n), raw_dim(p));
			if ($urandom_range(0, 7) == 0) begin
				send_load($urandom_range(1, total - 1), fill);
				loads_dropped++;
			end else begin
				repeat ($urandom_range(1, 2)) send_load(total, fill);
			end
			settle();
		end

		$display("Run summary: %0d elements sent under %0d register settings, %0d loads abandoned,",
			elems_sent, settings_used, loads_dropped);
		$display("             %0d result elements compared, %0d mismatches",
			checked_results, fail_count);
		if (fail_count == 0 && open_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
